FILE: hdl/sts_pkg.sv
// ---------------------------------------------------------------------------
// sts_pkg - shared types, constants and font for the scrolling text scanner
// Register map codes, config/scan structs and the 26-letter glyph table.
// ---------------------------------------------------------------------------
package sts_pkg;

   localparam int LETTER_W   = 5;
   localparam int NUM_SLOTS  = 12;
   localparam int LETTERS_W  = NUM_SLOTS * LETTER_W;
   localparam int LEN_W      = 4;
   localparam int TICKS_W    = 10;
   localparam int ROW_W      = 3;
   localparam int PAIR_W     = 4;
   localparam int COLS       = 8;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;

   localparam logic [LETTER_W-1:0] CODE_MAX    = 5'd25;
   localparam logic [COLS-1:0]     BLANK_ROW   = 8'hFF;
   localparam logic [ROW_W-1:0]    LAST_ROW    = 3'd7;
   localparam logic [ROW_W-1:0]    LAST_OFFSET = 3'd7;
   localparam logic [LEN_W-1:0]    LEN_RESET   = 4'd12;
   localparam logic [TICKS_W-1:0]  TICKS_RESET = 10'd150;

   // Register index = paddr[4:3] (64-bit registers, 8-byte stride)
   typedef enum logic [1:0] {
      REG_LETTERS    = 2'd0,
      REG_LENGTH     = 2'd1,
      REG_STEP_TICKS = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [LETTERS_W-1:0] letters;
      logic [LEN_W-1:0]     length;
      logic [TICKS_W-1:0]   step_ticks;
   } cfg_type;

   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [ROW_W-1:0]  offset;
      logic [PAIR_W-1:0] pair;
   } view_type;

   // One glyph per entry, row 0 in the top byte; active low.
   localparam logic [63:0] FONT_ROM [26] = '{
      64'hFFE7DBBDBD81BDBD, 64'hFF83BDBD83BDBD83, 64'hFFE1DFBFBFBFDFE1,
      64'hFF87BBBDBDBDBB87, 64'hFF81BFBF81BFBF81, 64'hFF81BFBF81BFBFBF,
      64'hFFE1DFBFB1BDDDE1, 64'hFFBDBDBD81BDBDBD, 64'hFF81E7E7E7E7E781,
      64'hFFE1FBFBFBBBDBE7, 64'hFFBDBBB78FB7BBBD, 64'hFFBFBFBFBFBFBF81,
      64'hFFBD99A5BDBDBDBD, 64'hFFBD9DADB5B9BDBD, 64'hFFE7DBBDBDBDDBE7,
      64'hFF83BDBDBD83BFBF, 64'hFFE7DBBDBDDBE7F9, 64'hFF81BDBDBD83B7BB,
      64'hFFC1BFBFC3FDFD83, 64'hFF81E7E7E7E7E7E7, 64'hFFBDBDBDBDBDBDC3,
      64'hFFBDBDBDBDDBDBE7, 64'hFFBDBDBDA5A5A5DB, 64'hFFBDBDBDC3BDBDBD,
      64'hFFBDBDBDDBE7E7E7, 64'hFF81FDFBF7EFDF81
   };

   // Codes above Z read as blank.
   function automatic logic [COLS-1:0] glyph_row(input logic [LETTER_W-1:0] code,
                                                  input logic [ROW_W-1:0] row);
      logic [63:0] glyph;
      glyph = 64'hFFFF_FFFF_FFFF_FFFF;
      if (code <= CODE_MAX) begin
         glyph = FONT_ROM[code];
      end
      return glyph[{~row, 3'b000} +: COLS];
   endfunction

   // Length 0 counts as 1, anything above max_len as max_len.
   function automatic logic [LEN_W-1:0] used_length(input logic [LEN_W-1:0] len,
                                                     input logic [LEN_W-1:0] max_len);
      logic [LEN_W-1:0] n;
      n = len;
      if (n == '0) begin
         n = 4'd1;
      end
      if (n > max_len) begin
         n = max_len;
      end
      return n;
   endfunction

endpackage

FILE: hdl/sts_req_if.sv
// ---------------------------------------------------------------------------
// sts_req_if - tick request channel
// Valid/ready channel carrying one advance bit per word.
// ---------------------------------------------------------------------------
interface sts_req_if;
   logic valid;
   logic ready;
   logic advance;

   modport source (output valid, output advance, input ready);
   modport sink   (input valid, input advance, output ready);
endinterface

FILE: hdl/sts_rsp_if.sv
// ---------------------------------------------------------------------------
// sts_rsp_if - row drive response channel
// Valid/ready channel carrying row select and active-low column bits.
// ---------------------------------------------------------------------------
interface sts_rsp_if;
   import sts_pkg::*;
   logic            valid;
   logic            ready;
   logic [COLS-1:0] row_select;
   logic [COLS-1:0] column_bits;

   modport source (output valid, output row_select, output column_bits, input ready);
   modport sink   (input valid, input row_select, input column_bits, output ready);
endinterface

FILE: hdl/sts_sequencer.sv
// ---------------------------------------------------------------------------
// sts_sequencer - row scan, scroll step timer and pair sequencing
// Holds scan row, scroll offset, pair index and the step timer state.
// ---------------------------------------------------------------------------
module sts_sequencer #(
   parameter int MAX_LETTERS = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       tick,
   input  sts_pkg::cfg_type           cfg,
   output sts_pkg::view_type          view
);
   import sts_pkg::*;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LETTERS);

   logic [ROW_W-1:0]   row_ff,     row_in;
   logic [ROW_W-1:0]   offset_ff,  offset_in;
   logic [PAIR_W-1:0]  pair_ff,    pair_in;
   logic [TICKS_W-1:0] count_ff,   count_in;
   logic               pending_ff, pending_in;
   logic [LEN_W-1:0]   n;

   assign n = used_length(cfg.length, MAX_LEN);

   always_comb begin
      row_in     = row_ff;
      offset_in  = offset_ff;
      pair_in    = pair_ff;
      count_in   = count_ff;
      pending_in = pending_ff;
      if (tick) begin
         count_in = count_ff + 10'd1;
         if (count_in >= cfg.step_ticks) begin
            count_in   = '0;
            pending_in = 1'b1;
         end
         row_in = row_ff + 3'd1;
         // frame boundary: take a pending scroll step
         if (row_ff == LAST_ROW && pending_in) begin
            pending_in = 1'b0;
            offset_in  = offset_ff + 3'd1;
            if (offset_ff == LAST_OFFSET) begin
               pair_in = (pair_ff >= n) ? '0 : pair_ff + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= '0;
         offset_ff  <= '0;
         pair_ff    <= '0;
         count_ff   <= '0;
         pending_ff <= 1'b0;
      end else begin
         row_ff     <= row_in;
         offset_ff  <= offset_in;
         pair_ff    <= pair_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
      end
   end

   assign view.row    = row_ff;
   assign view.offset = offset_ff;
   assign view.pair   = pair_ff;

endmodule

FILE: hdl/sts_composer.sv
// ---------------------------------------------------------------------------
// sts_composer - column data for the current row
// Looks up the left and right glyph rows and merges them at the offset.
// ---------------------------------------------------------------------------
module sts_composer (
   input  sts_pkg::view_type                 view,
   input  logic [sts_pkg::LETTERS_W-1:0]     letters,
   input  logic [sts_pkg::LEN_W-1:0]         n,
   output logic [sts_pkg::COLS-1:0]          row_select,
   output logic [sts_pkg::COLS-1:0]          column_bits
);
   import sts_pkg::*;

   logic [LETTER_W-1:0] codes [NUM_SLOTS];
   logic [PAIR_W-1:0]   left_k;
   logic                left_ok, right_ok;
   logic [COLS-1:0]     left_row, right_row;
   logic [2*COLS-1:0]   merged;

   for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_slot
      assign codes[k] = letters[k*LETTER_W +: LETTER_W];
   end

   assign left_k   = view.pair - 4'd1;
   assign left_ok  = (view.pair != '0) && (left_k < n);
   assign right_ok = view.pair < n;

   assign left_row  = left_ok  ? glyph_row(codes[left_k], view.row)    : BLANK_ROW;
   assign right_row = right_ok ? glyph_row(codes[view.pair], view.row) : BLANK_ROW;

   // right glyph slides in from the right edge
   assign merged      = {left_row, right_row} << view.offset;
   assign column_bits = merged[2*COLS-1:COLS];
   assign row_select  = COLS'(1) << view.row;

endmodule

FILE: hdl/scrolling_text_led_matrix_scanner_unit.sv
// ---------------------------------------------------------------------------
// scrolling_text_led_matrix_scanner_unit - 8x8 LED matrix scrolling text
// Top level: APB register file, scan sequencer, row composer, output stage.
// ---------------------------------------------------------------------------
// Each request word is one millisecond tick (advance = 1) or a hold
// (advance = 0). Every request word yields exactly one response word: the
// one-hot row select and active-low column bits of the current scan row;
// a tick then moves the scan to the next row. The message scrolls one column
// per step_ticks ticks, applied at the frame boundary. Throughput is one
// word per clock unless the response side stalls. The only stage is the
// response register, valid in the cycle after a request is accepted; req
// ready is high whenever it is empty or being drained in the same cycle.
// Registers (64-bit data, byte address 8*i): 0 message_letters, 1 message_length,
// 2 step_ticks. Change them only while no words are in flight.
// ---------------------------------------------------------------------------
module scrolling_text_led_matrix_scanner_unit #(
   parameter int MAX_LETTERS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   sts_req_if.sink                           req_ch,
   sts_rsp_if.source                         rsp_ch,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [sts_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [sts_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [sts_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import sts_pkg::*;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LETTERS);

   // ---- register file ----------------------------------------------------
   cfg_type       cfg_ff, cfg_in;
   reg_index_type reg_sel;
   logic          csr_write;

   assign pready    = 1'b1;
   assign reg_sel   = reg_index_type'(paddr[4:3]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_sel)
            REG_LETTERS:    cfg_in.letters    = pwdata[LETTERS_W-1:0];
            REG_LENGTH:     cfg_in.length     = pwdata[LEN_W-1:0];
            REG_STEP_TICKS: cfg_in.step_ticks = pwdata[TICKS_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_LETTERS:    prdata = CSR_DATA_W'(cfg_ff.letters);
         REG_LENGTH:     prdata = CSR_DATA_W'(cfg_ff.length);
         REG_STEP_TICKS: prdata = CSR_DATA_W'(cfg_ff.step_ticks);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.letters    <= '0;
         cfg_ff.length     <= LEN_RESET;
         cfg_ff.step_ticks <= TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---- handshake --------------------------------------------------------
   logic req_fire;
   logic rsp_valid_ff, rsp_valid_in;

   // accept while the response register is free or emptying this cycle
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;

   // ---- scan state -------------------------------------------------------
   view_type view;

   sts_sequencer #(
      .MAX_LETTERS (MAX_LETTERS)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .tick  (req_fire && req_ch.advance),
      .cfg   (cfg_ff),
      .view  (view)
   );

   // ---- row composition --------------------------------------------------
   logic [COLS-1:0] row_sel_now, cols_now;

   sts_composer u_comp (
      .view        (view),
      .letters     (cfg_ff.letters),
      .n           (used_length(cfg_ff.length, MAX_LEN)),
      .row_select  (row_sel_now),
      .column_bits (cols_now)
   );

   // ---- response register ------------------------------------------------
   logic [COLS-1:0] row_sel_ff, cols_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         row_sel_ff <= row_sel_now;
         cols_ff    <= cols_now;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.row_select  = row_sel_ff;
   assign rsp_ch.column_bits = cols_ff;

   // ---- assertions -------------------------------------------------------
   a_row_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> $onehot(rsp_ch.row_select))
      else $error("row select not one-hot");

   a_row_steps: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.advance) |=> (view.row == $past(view.row) + 3'd1))
      else $error("scan row did not step on a tick");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_ch.advance) |=> $stable(view))
      else $error("scan state moved on a hold word");

   a_pair_bound: assert property (@(posedge clock) disable iff (reset)
      view.pair <= PAIR_W'(MAX_LETTERS))
      else $error("pair index beyond message");

   a_rsp_row: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (rsp_ch.valid && rsp_ch.row_select == (COLS'(1) << $past(view.row))))
      else $error("response row does not match scan row");

endmodule
